FILE: sv/strict_json_syntax_validator_top_macros.svh
// assertion helpers
`ifndef STRICT_JSON_SYNTAX_VALIDATOR_TOP_MACROS_SVH
`define STRICT_JSON_SYNTAX_VALIDATOR_TOP_MACROS_SVH
`define SJV_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);
`define SJV_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);
`endif

FILE: sv/sjv_pkg.sv
`timescale 1ns / 1ps
package sjv_pkg;
  localparam int STACK_DEPTH = 64;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = 7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_VALID = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_DEEP = 2'd3;

  localparam logic [4:0] M_ROOT = 5'd0;
  localparam logic [4:0] M_AFTER_ROOT = 5'd1;
  localparam logic [4:0] M_ARR_FIRST = 5'd2;
  localparam logic [4:0] M_ARR_NEXT = 5'd3;
  localparam logic [4:0] M_OBJ_FIRST = 5'd4;
  localparam logic [4:0] M_OBJ_NEXT = 5'd5;
  localparam logic [4:0] M_COLON = 5'd6;
  localparam logic [4:0] M_VALUE = 5'd7;
  localparam logic [4:0] M_AFTER_VALUE = 5'd8;
  localparam logic [4:0] M_LIT_TRUE = 5'd9;
  localparam logic [4:0] M_LIT_FALSE = 5'd10;
  localparam logic [4:0] M_LIT_NULL = 5'd11;
  localparam logic [4:0] M_N_MINUS = 5'd12;
  localparam logic [4:0] M_N_ZERO = 5'd13;
  localparam logic [4:0] M_N_INT = 5'd14;
  localparam logic [4:0] M_N_DOT = 5'd15;
  localparam logic [4:0] M_N_FRAC = 5'd16;
  localparam logic [4:0] M_N_E = 5'd17;
  localparam logic [4:0] M_N_ESIGN = 5'd18;
  localparam logic [4:0] M_N_EXP = 5'd19;
  localparam logic [4:0] M_VSTR = 5'd20;
  localparam logic [4:0] M_KSTR = 5'd26;

  localparam logic [2:0] S_BODY = 3'd0;
  localparam logic [2:0] S_ESC = 3'd1;
  localparam logic [2:0] S_HEX = 3'd2;
  localparam logic [2:0] S_UTF8 = 3'd3;
  localparam logic [2:0] S_LOWBS = 3'd4;
  localparam logic [2:0] S_LOWU = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [DEPTH_W-1:0] current_depth;
    logic               end_of_document;
  } out_item_t;

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = 8'd0;
    case (k)
      2'd0: case (i) 3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
        default: c = 8'd0; endcase
      2'd1: case (i) 3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
        3'd4: c = "e"; default: c = 8'd0; endcase
      2'd2: case (i) 3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
        default: c = 8'd0; endcase
      default: c = 8'd0;
    endcase
    return c;
  endfunction
endpackage

FILE: sv/strict_json_syntax_validator_top.sv
`timescale 1ns / 1ps
// strict json syntax validator, one document byte per transfer
// in channel: in_valid / in_stall / in_data (data_byte, last_byte)
// out channel: out_valid / out_stall / out_data (status, current_depth,
//   end_of_document); exactly one result per accepted byte, in order
// cfg channel: cfg_valid / cfg_ready / cfg_data sets max_nesting (6 bits);
//   cfg_ready is always high, write only while idle
// a byte's result is registered, in the skid slot while the output is held
// throughput: one byte per cycle; the parse state updates in the same cycle
//   the byte is taken, the container stack is a memory written on open, its
//   top two entries sit in registers and the entry below them is read into
//   them on close; only in_stall limits rate beyond the single update path
// a one-entry output register with a skid slot lets a byte be taken while a
//   result waits; in_stall rises only when both slots are full
// reset: parse state, error and depth clear, max_nesting returns to 32; the
//   container stack is not cleared, entries are written before being read
// after the last byte the parse state restarts for the next document
module strict_json_syntax_validator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sjv_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sjv_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);
  `include "strict_json_syntax_validator_top_macros.svh"

  localparam int SD = sjv_pkg::STACK_DEPTH;
  localparam int DW = sjv_pkg::DEPTH_W;
  localparam int SW = sjv_pkg::SP_W;

  logic          stack [SD];
  logic [DW-1:0] depth, depth_next;
  logic [4:0]    mode, mode_next;
  logic [2:0]    lit, lit_next;
  logic [1:0]    u8rem, u8rem_next;
  logic [1:0]    u8cls, u8cls_next;
  logic [20:0]   acc, acc_next;
  logic [2:0]    hexcnt, hexcnt_next;
  logic [9:0]    hisur, hisur_next;
  logic [1:0]    err, err_next;
  logic [5:0]    max_nesting;
  logic          push, push_bit, pop;

  sjv_pkg::out_item_t res, skid;
  logic          skid_valid;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign in_stall = skid_valid;
  assign accept = in_valid && !in_stall;

  logic [7:0] b;
  assign b = in_data.data_byte;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction
  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  logic top_bit, below_bit;
  logic [SW-1:0] rd_idx;
  assign rd_idx = SW'(depth - DW'(3));

  logic [4:0] base;
  logic [2:0] sub;
  logic [4:0] hv;
  logic [15:0] hacc;
  logic [20:0] cacc;
  logic [20:0] cmin;
  logic [1:0] fin;
  logic [1:0] lk;
  logic [2:0] llen;
  logic renter;
  logic [4:0] m;

  always_comb begin
    depth_next = depth; mode_next = mode; lit_next = lit; u8rem_next = u8rem;
    u8cls_next = u8cls; acc_next = acc; hexcnt_next = hexcnt; hisur_next = hisur;
    err_next = err; push = 1'b0; push_bit = 1'b0; pop = 1'b0;
    base = (mode >= sjv_pkg::M_KSTR) ? sjv_pkg::M_KSTR : sjv_pkg::M_VSTR;
    sub = 3'(mode - base);
    hv = 5'd16;
    if (is_dig(b)) hv = 5'(b - "0");
    else if (b >= "a" && b <= "f") hv = 5'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") hv = 5'(b - "A" + 8'd10);
    hacc = {acc[11:0], hv[3:0]};
    cacc = {acc[14:0], b[5:0]};
    cmin = (u8cls == 2'd1) ? 21'h80 : ((u8cls == 2'd2) ? 21'h800 : 21'h10000);
    lk = 2'(mode - sjv_pkg::M_LIT_TRUE);
    llen = (lk == 2'd1) ? 3'd5 : 3'd4;
    renter = 1'b0;
    m = mode;
    if (err == sjv_pkg::ST_OK) begin
      if (mode >= sjv_pkg::M_VSTR) begin
        case (sub)
          sjv_pkg::S_BODY: begin
            if (b == 8'h22) begin
              if (base == sjv_pkg::M_KSTR) mode_next = sjv_pkg::M_COLON;
              else mode_next = (depth == '0) ? sjv_pkg::M_AFTER_ROOT
                                             : sjv_pkg::M_AFTER_VALUE;
            end else if (b < 8'h20) err_next = sjv_pkg::ST_BAD;
            else if (b == 8'h5c) mode_next = base + 5'(sjv_pkg::S_ESC);
            else if (b >= 8'h80) begin
              if ((b & 8'he0) == 8'hc0) begin
                u8rem_next = 2'd1; acc_next = 21'(b[4:0]); u8cls_next = 2'd1;
                mode_next = base + 5'(sjv_pkg::S_UTF8);
              end else if ((b & 8'hf0) == 8'he0) begin
                u8rem_next = 2'd2; acc_next = 21'(b[3:0]); u8cls_next = 2'd2;
                mode_next = base + 5'(sjv_pkg::S_UTF8);
              end else if ((b & 8'hf8) == 8'hf0) begin
                u8rem_next = 2'd3; acc_next = 21'(b[2:0]); u8cls_next = 2'd3;
                mode_next = base + 5'(sjv_pkg::S_UTF8);
              end else err_next = sjv_pkg::ST_BAD;
            end
          end
          sjv_pkg::S_UTF8: begin
            if (b[7:6] != 2'b10 || u8rem == 2'd0) err_next = sjv_pkg::ST_BAD;
            else begin
              acc_next = cacc;
              u8rem_next = u8rem - 2'd1;
              if (u8rem == 2'd1) begin
                if (cacc < cmin || cacc > 21'h10ffff ||
                    (cacc >= 21'hd800 && cacc <= 21'hdfff)) err_next = sjv_pkg::ST_BAD;
                else begin
                  acc_next = '0; u8cls_next = 2'd0;
                  mode_next = base + 5'(sjv_pkg::S_BODY);
                end
              end
            end
          end
          sjv_pkg::S_ESC: begin
            if (b == 8'h22 || b == 8'h5c || b == "/" || b == "b" || b == "f" ||
                b == "n" || b == "r" || b == "t") mode_next = base + 5'(sjv_pkg::S_BODY);
            else if (b == "u") begin
              mode_next = base + 5'(sjv_pkg::S_HEX); hexcnt_next = 3'd0; acc_next = '0;
            end else err_next = sjv_pkg::ST_BAD;
          end
          sjv_pkg::S_HEX: begin
            if (hv[4]) err_next = sjv_pkg::ST_BAD;
            else begin
              acc_next = 21'(hacc);
              if (hexcnt == 3'd3) begin
                if (hacc >= 16'hd800 && hacc <= 16'hdbff) begin
                  hisur_next = 10'(hacc - 16'hd800);
                  mode_next = base + 5'(sjv_pkg::S_LOWBS);
                  hexcnt_next = 3'd0; acc_next = '0;
                end else if (hacc >= 16'hdc00 && hacc <= 16'hdfff) err_next = sjv_pkg::ST_BAD;
                else begin
                  mode_next = base + 5'(sjv_pkg::S_BODY);
                  hexcnt_next = 3'd0; acc_next = '0;
                end
              end else if (hexcnt == 3'd7) begin
                if (hacc < 16'hdc00 || hacc > 16'hdfff) err_next = sjv_pkg::ST_BAD;
                else begin
                  mode_next = base + 5'(sjv_pkg::S_BODY);
                  hexcnt_next = 3'd0; acc_next = '0; hisur_next = '0;
                end
              end else hexcnt_next = hexcnt + 3'd1;
            end
          end
          sjv_pkg::S_LOWBS: begin
            if (b == 8'h5c) mode_next = base + 5'(sjv_pkg::S_LOWU);
            else err_next = sjv_pkg::ST_BAD;
          end
          sjv_pkg::S_LOWU: begin
            if (b == "u") begin
              mode_next = base + 5'(sjv_pkg::S_HEX); hexcnt_next = 3'd4; acc_next = '0;
            end else err_next = sjv_pkg::ST_BAD;
          end
          default: err_next = sjv_pkg::ST_BAD;
        endcase
      end else begin
        if (mode >= sjv_pkg::M_N_MINUS) begin
          case (mode)
            sjv_pkg::M_N_MINUS:
              if (b == "0") mode_next = sjv_pkg::M_N_ZERO;
              else if (is_dig(b)) mode_next = sjv_pkg::M_N_INT;
              else err_next = sjv_pkg::ST_BAD;
            sjv_pkg::M_N_ZERO, sjv_pkg::M_N_INT:
              if (is_dig(b)) begin
                if (mode == sjv_pkg::M_N_ZERO) err_next = sjv_pkg::ST_BAD;
              end else if (b == ".") mode_next = sjv_pkg::M_N_DOT;
              else if (b == "e" || b == "E") mode_next = sjv_pkg::M_N_E;
              else renter = 1'b1;
            sjv_pkg::M_N_DOT:
              if (is_dig(b)) mode_next = sjv_pkg::M_N_FRAC;
              else err_next = sjv_pkg::ST_BAD;
            sjv_pkg::M_N_FRAC:
              if (b == "e" || b == "E") mode_next = sjv_pkg::M_N_E;
              else if (!is_dig(b)) renter = 1'b1;
            sjv_pkg::M_N_E:
              if (b == "+" || b == "-") mode_next = sjv_pkg::M_N_ESIGN;
              else if (is_dig(b)) mode_next = sjv_pkg::M_N_EXP;
              else err_next = sjv_pkg::ST_BAD;
            sjv_pkg::M_N_ESIGN:
              if (is_dig(b)) mode_next = sjv_pkg::M_N_EXP;
              else err_next = sjv_pkg::ST_BAD;
            default:
              if (!is_dig(b)) renter = 1'b1;
          endcase
          if (renter) m = (depth == '0) ? sjv_pkg::M_AFTER_ROOT : sjv_pkg::M_AFTER_VALUE;
          mode_next = renter ? m : mode_next;
        end
        if (mode < sjv_pkg::M_N_MINUS || renter) begin
          if (!(is_ws(b) && m <= sjv_pkg::M_AFTER_VALUE)) begin
            case (m)
              sjv_pkg::M_ROOT, sjv_pkg::M_VALUE, sjv_pkg::M_ARR_FIRST, sjv_pkg::M_ARR_NEXT: begin
                if (m == sjv_pkg::M_ARR_FIRST && b == "]") begin
                  if (depth == '0 || top_bit) err_next = sjv_pkg::ST_BAD;
                  else begin
                    pop = 1'b1;
                    depth_next = depth - DW'(1);
                    mode_next = (depth == DW'(1)) ? sjv_pkg::M_AFTER_ROOT
                                                  : sjv_pkg::M_AFTER_VALUE;
                  end
                end else if (m == sjv_pkg::M_ARR_NEXT && b == "]") err_next = sjv_pkg::ST_BAD;
                else if (depth > DW'(max_nesting)) err_next = sjv_pkg::ST_DEEP;
                else if (b == 8'h22) mode_next = sjv_pkg::M_VSTR;
                else if (b == "-") mode_next = sjv_pkg::M_N_MINUS;
                else if (b == "0") mode_next = sjv_pkg::M_N_ZERO;
                else if (is_dig(b)) mode_next = sjv_pkg::M_N_INT;
                else if (b == "t") begin mode_next = sjv_pkg::M_LIT_TRUE; lit_next = 3'd1; end
                else if (b == "f") begin mode_next = sjv_pkg::M_LIT_FALSE; lit_next = 3'd1; end
                else if (b == "n") begin mode_next = sjv_pkg::M_LIT_NULL; lit_next = 3'd1; end
                else if (b == "[" || b == "{") begin
                  if (depth >= DW'(SD)) err_next = sjv_pkg::ST_DEEP;
                  else begin
                    push = 1'b1; push_bit = (b == "{");
                    depth_next = depth + DW'(1);
                    mode_next = (b == "{") ? sjv_pkg::M_OBJ_FIRST : sjv_pkg::M_ARR_FIRST;
                  end
                end else err_next = sjv_pkg::ST_BAD;
              end
              sjv_pkg::M_AFTER_ROOT: err_next = sjv_pkg::ST_BAD;
              sjv_pkg::M_OBJ_FIRST, sjv_pkg::M_OBJ_NEXT: begin
                if (b == 8'h22) mode_next = sjv_pkg::M_KSTR;
                else if (b == "}" && m == sjv_pkg::M_OBJ_FIRST && depth != '0 && top_bit) begin
                  pop = 1'b1;
                  depth_next = depth - DW'(1);
                  mode_next = (depth == DW'(1)) ? sjv_pkg::M_AFTER_ROOT
                                                : sjv_pkg::M_AFTER_VALUE;
                end else err_next = sjv_pkg::ST_BAD;
              end
              sjv_pkg::M_COLON:
                if (b == ":") mode_next = sjv_pkg::M_VALUE;
                else err_next = sjv_pkg::ST_BAD;
              sjv_pkg::M_AFTER_VALUE: begin
                if (depth == '0) err_next = sjv_pkg::ST_BAD;
                else if (b == ",")
                  mode_next = top_bit ? sjv_pkg::M_OBJ_NEXT : sjv_pkg::M_ARR_NEXT;
                else if ((b == "]" && !top_bit) || (b == "}" && top_bit)) begin
                  pop = 1'b1;
                  depth_next = depth - DW'(1);
                  mode_next = (depth == DW'(1)) ? sjv_pkg::M_AFTER_ROOT
                                                : sjv_pkg::M_AFTER_VALUE;
                end else err_next = sjv_pkg::ST_BAD;
              end
              default: begin
                if (lk != 2'd3 && lit < llen && b == sjv_pkg::lit_char(lk, lit)) begin
                  lit_next = lit + 3'd1;
                  if (lit + 3'd1 == llen) begin
                    lit_next = 3'd0;
                    mode_next = (depth == '0) ? sjv_pkg::M_AFTER_ROOT
                                              : sjv_pkg::M_AFTER_VALUE;
                  end
                end else err_next = sjv_pkg::ST_BAD;
              end
            endcase
          end
        end
      end
    end
    fin = err_next;
    if (err_next == sjv_pkg::ST_OK) begin
      case (mode_next)
        sjv_pkg::M_AFTER_ROOT: fin = sjv_pkg::ST_VALID;
        sjv_pkg::M_N_ZERO, sjv_pkg::M_N_INT, sjv_pkg::M_N_FRAC, sjv_pkg::M_N_EXP:
          fin = (depth_next == '0) ? sjv_pkg::ST_VALID : sjv_pkg::ST_BAD;
        sjv_pkg::M_ARR_FIRST, sjv_pkg::M_ARR_NEXT, sjv_pkg::M_VALUE:
          fin = (depth_next > DW'(max_nesting)) ? sjv_pkg::ST_DEEP : sjv_pkg::ST_BAD;
        default: fin = sjv_pkg::ST_BAD;
      endcase
    end
  end

  sjv_pkg::out_item_t new_res;
  always_comb begin
    new_res.status = in_data.last_byte ? fin : err_next;
    new_res.current_depth = depth_next;
    new_res.end_of_document = in_data.last_byte;
  end

  // container stack: memory below, top two entries in registers
  always_ff @(posedge clk) begin
    if (accept && push) stack[SW'(depth)] <= push_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_bit <= 1'b0; below_bit <= 1'b0;
    end else if (accept && push) begin
      top_bit <= push_bit; below_bit <= top_bit;
    end else if (accept && pop) begin
      top_bit <= below_bit; below_bit <= stack[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0; mode <= sjv_pkg::M_ROOT; lit <= '0; u8rem <= '0; u8cls <= '0;
      acc <= '0; hexcnt <= '0; hisur <= '0; err <= sjv_pkg::ST_OK;
    end else if (accept) begin
      if (in_data.last_byte) begin
        depth <= '0; mode <= sjv_pkg::M_ROOT; lit <= '0; u8rem <= '0; u8cls <= '0;
        acc <= '0; hexcnt <= '0; hisur <= '0; err <= sjv_pkg::ST_OK;
      end else begin
        depth <= depth_next; mode <= mode_next; lit <= lit_next; u8rem <= u8rem_next;
        u8cls <= u8cls_next; acc <= acc_next; hexcnt <= hexcnt_next;
        hisur <= hisur_next; err <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) max_nesting <= 6'd32;
    else if (cfg_valid && cfg_ready) max_nesting <= cfg_data;
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_valid <= 1'b1; skid_valid <= 1'b0;
        end else out_valid <= accept;
      end else if (accept) skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) res <= skid_valid ? skid : new_res;
    if (out_valid && out_stall && accept) skid <= new_res;
  end

  assign out_data = res;

  `SJV_ASSERT_IMP(a_skid_only_when_held, skid_valid, out_valid, "skid full with output empty")
  `SJV_ASSERT_NXT(a_restart_after_last, accept && in_data.last_byte,
    depth == '0 && err == sjv_pkg::ST_OK, "state not restarted after last byte")
  `SJV_ASSERT_NXT(a_error_sticky, err != sjv_pkg::ST_OK && !(accept && in_data.last_byte),
    err == $past(err), "error changed before end of document")
endmodule

FILE: tb/strict_json_syntax_validator_top_tb.sv
`timescale 1ns / 1ps
module strict_json_syntax_validator_top_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sjv_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sjv_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_data = '0;

  int errors = 0;
  int idle_pct = 17;
  int hold_off = 0;
  byte doc_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  strict_json_syntax_validator_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class json_scoreboard;
    bit stk[sjv_pkg::STACK_DEPTH];
    int depth, mode, litp, u8rem, u8cls, acc, hexn, err, maxn;
    sjv_pkg::out_item_t pending[$];

    function void restart();
      depth = 0; mode = sjv_pkg::M_ROOT; litp = 0; u8rem = 0; u8cls = 0;
      acc = 0; hexn = 0; err = 0;
    endfunction

    function void fail(int c);
      if (err == 0) err = c;
    endfunction

    function bit ws(int b);
      return b == " " || b == 9 || b == 10 || b == 13;
    endfunction

    function bit dig(int b);
      return b >= "0" && b <= "9";
    endfunction

    function int hexv(int b);
      if (dig(b)) return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return 16;
    endfunction

    function void done_value();
      mode = (depth == 0) ? sjv_pkg::M_AFTER_ROOT : sjv_pkg::M_AFTER_VALUE;
    endfunction

    function void close_it(bit kind);
      if (depth == 0 || depth > sjv_pkg::STACK_DEPTH || stk[depth-1] != kind) begin
        fail(sjv_pkg::ST_BAD);
        return;
      end
      depth--;
      done_value();
    endfunction

    function void open_value(int b);
      if (depth > maxn) begin fail(sjv_pkg::ST_DEEP); return; end
      if (b == "\"") mode = sjv_pkg::M_VSTR;
      else if (b == "-") mode = sjv_pkg::M_N_MINUS;
      else if (b == "0") mode = sjv_pkg::M_N_ZERO;
      else if (dig(b)) mode = sjv_pkg::M_N_INT;
      else if (b == "t") begin mode = sjv_pkg::M_LIT_TRUE; litp = 1; end
      else if (b == "f") begin mode = sjv_pkg::M_LIT_FALSE; litp = 1; end
      else if (b == "n") begin mode = sjv_pkg::M_LIT_NULL; litp = 1; end
      else if (b == "[" || b == "{") begin
        if (depth >= sjv_pkg::STACK_DEPTH) begin fail(sjv_pkg::ST_DEEP); return; end
        stk[depth] = (b == "{");
        depth++;
        mode = (b == "{") ? sjv_pkg::M_OBJ_FIRST : sjv_pkg::M_ARR_FIRST;
      end else fail(sjv_pkg::ST_BAD);
    endfunction

    function void str_byte(int b);
      int base, sub, v, mn;
      base = (mode >= sjv_pkg::M_KSTR) ? sjv_pkg::M_KSTR : sjv_pkg::M_VSTR;
      sub = mode - base;
      case (sub)
        sjv_pkg::S_BODY: begin
          if (b == "\"") begin
            if (base == sjv_pkg::M_KSTR) mode = sjv_pkg::M_COLON; else done_value();
          end else if (b < 8'h20) fail(sjv_pkg::ST_BAD);
          else if (b == "\\") mode = base + sjv_pkg::S_ESC;
          else if (b >= 8'h80) begin
            if ((b & 8'he0) == 8'hc0) begin u8rem = 1; acc = b & 8'h1f; u8cls = 1; end
            else if ((b & 8'hf0) == 8'he0) begin u8rem = 2; acc = b & 8'h0f; u8cls = 2; end
            else if ((b & 8'hf8) == 8'hf0) begin u8rem = 3; acc = b & 8'h07; u8cls = 3; end
            else begin fail(sjv_pkg::ST_BAD); return; end
            mode = base + sjv_pkg::S_UTF8;
          end
        end
        sjv_pkg::S_UTF8: begin
          if ((b & 8'hc0) != 8'h80 || u8rem == 0) begin fail(sjv_pkg::ST_BAD); return; end
          acc = ((acc << 6) | (b & 8'h3f)) & 21'h1fffff;
          u8rem--;
          if (u8rem == 0) begin
            mn = (u8cls == 1) ? 'h80 : (u8cls == 2) ? 'h800 : 'h10000;
            if (acc < mn || acc > 'h10ffff || (acc >= 'hd800 && acc <= 'hdfff)) begin
              fail(sjv_pkg::ST_BAD);
              return;
            end
            acc = 0; u8cls = 0; mode = base + sjv_pkg::S_BODY;
          end
        end
        sjv_pkg::S_ESC: begin
          if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" || b == "n" ||
              b == "r" || b == "t") mode = base + sjv_pkg::S_BODY;
          else if (b == "u") begin mode = base + sjv_pkg::S_HEX; hexn = 0; acc = 0; end
          else fail(sjv_pkg::ST_BAD);
        end
        sjv_pkg::S_HEX: begin
          v = hexv(b);
          if (v > 15) begin fail(sjv_pkg::ST_BAD); return; end
          acc = ((acc << 4) | v) & 'hffff;
          if (hexn == 3) begin
            if (acc >= 'hd800 && acc <= 'hdbff) mode = base + sjv_pkg::S_LOWBS;
            else if (acc >= 'hdc00 && acc <= 'hdfff) begin fail(sjv_pkg::ST_BAD); return; end
            else mode = base + sjv_pkg::S_BODY;
            hexn = 0; acc = 0;
          end else if (hexn >= 7) begin
            if (acc < 'hdc00 || acc > 'hdfff) begin fail(sjv_pkg::ST_BAD); return; end
            mode = base + sjv_pkg::S_BODY; hexn = 0; acc = 0;
          end else hexn++;
        end
        sjv_pkg::S_LOWBS:
          if (b == "\\") mode = base + sjv_pkg::S_LOWU; else fail(sjv_pkg::ST_BAD);
        sjv_pkg::S_LOWU: begin
          if (b == "u") begin mode = base + sjv_pkg::S_HEX; hexn = 4; acc = 0; end
          else fail(sjv_pkg::ST_BAD);
        end
        default: fail(sjv_pkg::ST_BAD);
      endcase
    endfunction

    // returns 1 when the number ended and the byte must be looked at again
    function bit num_byte(int b);
      bit d, e;
      d = dig(b);
      e = (b == "e" || b == "E");
      case (mode)
        sjv_pkg::M_N_MINUS: begin
          if (b == "0") mode = sjv_pkg::M_N_ZERO;
          else if (d) mode = sjv_pkg::M_N_INT;
          else fail(sjv_pkg::ST_BAD);
          return 0;
        end
        sjv_pkg::M_N_ZERO, sjv_pkg::M_N_INT: begin
          if (d) begin if (mode == sjv_pkg::M_N_ZERO) fail(sjv_pkg::ST_BAD); return 0; end
          if (b == ".") begin mode = sjv_pkg::M_N_DOT; return 0; end
          if (e) begin mode = sjv_pkg::M_N_E; return 0; end
        end
        sjv_pkg::M_N_DOT: begin
          if (d) mode = sjv_pkg::M_N_FRAC; else fail(sjv_pkg::ST_BAD);
          return 0;
        end
        sjv_pkg::M_N_FRAC: begin
          if (d) return 0;
          if (e) begin mode = sjv_pkg::M_N_E; return 0; end
        end
        sjv_pkg::M_N_E: begin
          if (b == "+" || b == "-") mode = sjv_pkg::M_N_ESIGN;
          else if (d) mode = sjv_pkg::M_N_EXP;
          else fail(sjv_pkg::ST_BAD);
          return 0;
        end
        sjv_pkg::M_N_ESIGN: begin
          if (d) mode = sjv_pkg::M_N_EXP; else fail(sjv_pkg::ST_BAD);
          return 0;
        end
        default: if (d) return 0;
      endcase
      done_value();
      return 1;
    endfunction

    function void lit_byte(int b);
      int k, n;
      string txt;
      k = mode - sjv_pkg::M_LIT_TRUE;
      txt = (k == 0) ? "true" : (k == 1) ? "false" : "null";
      n = txt.len();
      if (k < 3 && litp < n && b == txt[litp]) begin
        litp++;
        if (litp == n) begin litp = 0; done_value(); end
      end else fail(sjv_pkg::ST_BAD);
    endfunction

    function void take_byte(int b);
      for (int pass = 0; pass < 2 && err == 0; pass++) begin
        if (mode >= sjv_pkg::M_VSTR) begin str_byte(b); return; end
        if (mode >= sjv_pkg::M_N_MINUS && mode <= sjv_pkg::M_N_EXP) begin
          if (!num_byte(b)) return;
          continue;
        end
        if (ws(b) && mode <= sjv_pkg::M_AFTER_VALUE) return;
        case (mode)
          sjv_pkg::M_ROOT, sjv_pkg::M_VALUE: open_value(b);
          sjv_pkg::M_AFTER_ROOT: fail(sjv_pkg::ST_BAD);
          sjv_pkg::M_ARR_FIRST: if (b == "]") close_it(0); else open_value(b);
          sjv_pkg::M_ARR_NEXT: if (b == "]") fail(sjv_pkg::ST_BAD); else open_value(b);
          sjv_pkg::M_OBJ_FIRST, sjv_pkg::M_OBJ_NEXT: begin
            if (b == "\"") mode = sjv_pkg::M_KSTR;
            else if (b == "}" && mode == sjv_pkg::M_OBJ_FIRST) close_it(1);
            else fail(sjv_pkg::ST_BAD);
          end
          sjv_pkg::M_COLON: if (b == ":") mode = sjv_pkg::M_VALUE; else fail(sjv_pkg::ST_BAD);
          sjv_pkg::M_AFTER_VALUE: begin
            if (depth == 0 || depth > sjv_pkg::STACK_DEPTH) fail(sjv_pkg::ST_BAD);
            else if (b == ",")
              mode = stk[depth-1] ? sjv_pkg::M_OBJ_NEXT : sjv_pkg::M_ARR_NEXT;
            else if (b == "]" && !stk[depth-1]) close_it(0);
            else if (b == "}" && stk[depth-1]) close_it(1);
            else fail(sjv_pkg::ST_BAD);
          end
          default: lit_byte(b);
        endcase
        return;
      end
    endfunction

    function int end_status();
      if (err != 0) return err;
      case (mode)
        sjv_pkg::M_AFTER_ROOT: return sjv_pkg::ST_VALID;
        sjv_pkg::M_N_ZERO, sjv_pkg::M_N_INT, sjv_pkg::M_N_FRAC, sjv_pkg::M_N_EXP:
          return depth == 0 ? sjv_pkg::ST_VALID : sjv_pkg::ST_BAD;
        sjv_pkg::M_ARR_FIRST, sjv_pkg::M_ARR_NEXT, sjv_pkg::M_VALUE:
          return depth > maxn ? sjv_pkg::ST_DEEP : sjv_pkg::ST_BAD;
        default: return sjv_pkg::ST_BAD;
      endcase
    endfunction

    function void note_input(sjv_pkg::in_item_t it);
      sjv_pkg::out_item_t r;
      if (err == 0) take_byte(int'(it.data_byte));
      r.status = 2'(it.last_byte ? end_status() : err);
      r.current_depth = 7'(depth);
      r.end_of_document = it.last_byte;
      pending.insert(pending.size(), r);
      if (it.last_byte) restart();
    endfunction

    task check_result(sjv_pkg::out_item_t got);
      sjv_pkg::out_item_t w;
      if (pending.size() == 0) begin
        report("unexpected result", got, 0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.current_depth !== w.current_depth)
        report("current_depth", got.current_depth, w.current_depth);
      if (got.end_of_document !== w.end_of_document)
        report("end_of_document", got.end_of_document, w.end_of_document);
    endtask
  endclass

  json_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(in_data);
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic send_byte(input byte b, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_doc(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_queue();
    for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
    doc_q.delete();
  endtask

  task automatic set_limit(input logic [5:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.maxn = v;
  endtask

  function automatic void add_byte(input byte v);
    doc_q.insert(doc_q.size(), v);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void gen_string();
    int n;
    add_byte("\"");
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: put_str("\\n");
        1: put_str("\\u00e9");
        2: put_str("\\ud83d\\ude00");
        3: begin add_byte(8'hc3); add_byte(8'ha9); end
        4: begin add_byte(8'he2); add_byte(8'h82); add_byte(8'hac); end
        5: begin
          add_byte(8'hf0); add_byte(8'h9f);
          add_byte(8'h98); add_byte(8'h80);
        end
        6: add_byte($urandom_range(255));
        default: add_byte($urandom_range(8'h7e, 8'h20) == "\"" ? "a" : "b");
      endcase
    end
    add_byte("\"");
  endfunction

  function automatic void gen_value(input int lvl);
    int k, n;
    k = (lvl > 4) ? $urandom_range(5) : $urandom_range(7);
    case (k)
      0: put_str("true");
      1: put_str("false");
      2: put_str("null");
      3: gen_string();
      4: put_str($sformatf("-%0d.%0de+%0d", $urandom_range(99), $urandom_range(9),
                           $urandom_range(9)));
      5: put_str($sformatf("%0d", $urandom_range(999)));
      6: begin
        add_byte("[");
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i) add_byte(",");
          if ($urandom_range(3) == 0) add_byte(" ");
          gen_value(lvl + 1);
        end
        add_byte("]");
      end
      default: begin
        add_byte("{");
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i) add_byte(",");
          gen_string();
          add_byte(":");
          gen_value(lvl + 1);
        end
        add_byte("}");
      end
    endcase
  endfunction

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int sent;
    sb.restart();
    sb.maxn = 32;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_doc("{\"a\":[1,-0.5e+3,true,false,null]}");
    send_doc(" 0 ");
    send_doc("12");
    send_doc("[1,]");
    send_doc("\"\\ud800\\udc00\\u00ff\"");
    send_doc("\"\\udc00\"");
    doc_q = '{"\"", 8'hc0, 8'h80, "\""};
    send_queue();
    doc_q = '{"\"", 8'hed, 8'ha0, 8'h80, "\""};
    send_queue();
    doc_q = '{"\"", 8'hf4, 8'h90, 8'h80, 8'h80, "\""};
    send_queue();
    doc_q = '{"\"", 8'h01, "\""};
    send_queue();
    send_doc("[");
    send_byte(8'hff, 1'b1);
    set_limit(6'd0);
    send_doc("[[]]");
    send_doc("[");
    set_limit(6'd63);
    doc_q.delete();
    for (int i = 0; i < 66; i++) add_byte("[");
    send_queue();
    set_limit(6'd2);
    // long receiver hold-off while bytes keep coming
    hold_off <= 60;
    send_doc("[[[1]]]  ");
    sent = 0;
    idle_pct = 0;
    while (sent < 880) begin
      if (sent > 300) idle_pct = 17;
      if (sent > 350 && sent < 400) set_limit($urandom_range(63));
      if ($urandom_range(9) == 0) set_limit($urandom_range(1) ? 6'd63 : $urandom_range(5));
      gen_value(0);
      if ($urandom_range(7) == 0) doc_q.insert($urandom_range(doc_q.size() - 1),
                                               $urandom_range(255));
      if ($urandom_range(9) == 0) add_byte(" ");
      if ($urandom_range(15) == 0) doc_q.delete(doc_q.size() - 1);
      if (doc_q.size() == 0) add_byte($urandom_range(255));
      sent += doc_q.size();
      send_queue();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/sjv_pkg.sv
sv/strict_json_syntax_validator_top.sv
tb/strict_json_syntax_validator_top_tb.sv
